// ----- src/set_assoc_lru_cache_model_macros.svh -----
// Assertion macros used by the cache model RTL.
`ifndef SET_ASSOC_LRU_CACHE_MODEL_MACROS_SVH
`define SET_ASSOC_LRU_CACHE_MODEL_MACROS_SVH
// Assert that a condition implies a consequent in the same cycle.
`define SALC_ASSERT_IMPL(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error("assertion failed");
// Assert that a condition implies a consequent in the next cycle.
`define SALC_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- src/salc_pkg.sv -----
// Package with types, constants and helpers for the cache model.
package salc_pkg;
  localparam int MAX_SETS_DEF = 1024;
  localparam int MAX_WAYS_DEF = 8;
  localparam int TAG_W        = 64;
  localparam int AGE_W        = 3;
  localparam int CNT_W        = 32;
  localparam logic [AGE_W-1:0] AGE_MAX = 3'd7;
  localparam logic [CNT_W-1:0] CNT_MAX = 32'hFFFF_FFFF;

  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_STORE  = 2'd1;
  localparam logic [1:0] REQ_MODIFY = 2'd2;
  localparam logic [1:0] REQ_IFETCH = 2'd3;

  localparam logic [1:0] OUT_HIT   = 2'd0;
  localparam logic [1:0] OUT_FILL  = 2'd1;
  localparam logic [1:0] OUT_EVICT = 2'd2;

  localparam logic [1:0] CFG_SET_BITS = 2'd0;
  localparam logic [1:0] CFG_WAYS     = 2'd1;
  localparam logic [1:0] CFG_BLK_BITS = 2'd2;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 104;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [AGE_W-1:0] age_inc(input logic [AGE_W-1:0] a);
    return (a == AGE_MAX) ? a : a + 1'b1;
  endfunction
endpackage

// ----- src/set_assoc_lru_cache_model.sv -----
// Top level of the tag-only set-associative cache model with true LRU.
//
// A user of this block should know: each load or store item gives one result
// item, a modify gives two (load, then store, tlast on the second), an
// instruction fetch gives none. An item is taken in the idle state; every
// lookup then passes through a read state, which reads the set's row out of
// the synchronous tag/state memory, and a compare state, which compares all
// ways in parallel, picks the hit, free or oldest way and writes the row
// back; a fetch is taken in the idle state and does no lookup. The memory
// holds one row per set, with valid, tag and age for every way, so a row
// write is finished before the next lookup reads it. Tags keep all 64 bits
// of the shifted address, so very small set and block widths still compare
// exactly. Valid bits live in the memory too; after reset a clearing pass
// writes every row empty, one row per cycle, during which no item is accepted.
// The result sits in an output register; the next item is taken while it
// waits, and a lookup only stalls when that register is still full.
module set_assoc_lru_cache_model #(
  parameter int MAX_SETS = salc_pkg::MAX_SETS_DEF,
  parameter int MAX_WAYS = salc_pkg::MAX_WAYS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [1:0]                       cfg_index,
  input  logic [5:0]                       cfg_wdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // tdata: req_type[1:0], address[65:2], zero pad [71:66]
  input  logic [salc_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // tdata: outcome[1:0], hit_total[33:2], miss_total[65:34],
  //        evict_total[97:66], zero pad [103:98]
  output logic [salc_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                             out_tlast
);
  import salc_pkg::*;
  `include "set_assoc_lru_cache_model_macros.svh"

  localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WCNT_W = $clog2(MAX_WAYS + 1);
  localparam int ENT_W  = 1 + TAG_W + AGE_W;
  localparam int ROW_W  = ENT_W * MAX_WAYS;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_COMP  = 3'd3;

  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
    logic [AGE_W-1:0] age;
  } entry_t;

  logic [ROW_W-1:0] mem [MAX_SETS];
  logic [ROW_W-1:0] rd_row_r;

  logic [2:0]       state_r, state_nxt;
  logic [SET_W:0]   clr_cnt_r, clr_cnt_nxt;
  logic [3:0]       set_bits_r;
  logic [3:0]       ways_r;
  logic [5:0]       blk_bits_r;
  logic [SET_W-1:0] set_r, set_nxt;
  logic [TAG_W-1:0] tag_r, tag_nxt;
  logic             second_r, second_nxt;
  logic             modify_r, modify_nxt;
  logic [CNT_W-1:0] hits_r, hits_nxt, miss_r, miss_nxt, evict_r, evict_nxt;
  logic             ovalid_r, ovalid_nxt;
  logic [1:0]       oout_r, oout_nxt;
  logic             olast_r, olast_nxt;

  logic             mem_we;
  logic [SET_W-1:0] mem_waddr;
  logic [ROW_W-1:0] mem_wrow;
  logic             mem_re;

  // Request decode: set index and tag from the address.
  logic [1:0]       req_type;
  logic [63:0]      req_addr;
  logic [63:0]      shifted;
  logic [6:0]       sh_sum;
  logic [63:0]      idx_full;
  logic [63:0]      tag_full;
  assign req_type = in_tdata[1:0];
  assign req_addr = in_tdata[65:2];
  assign shifted  = req_addr >> blk_bits_r;
  assign idx_full = shifted & ((64'd1 << set_bits_r) - 64'd1);
  assign sh_sum   = {3'd0, set_bits_r} + {1'b0, blk_bits_r};
  assign tag_full = (sh_sum >= 7'd64) ? 64'd0 : (req_addr >> sh_sum);

  logic [WCNT_W-1:0] ways_eff;
  always_comb begin
    if (ways_r == 4'd0) ways_eff = WCNT_W'(1);
    else if ({28'd0, ways_r} > MAX_WAYS) ways_eff = WCNT_W'(MAX_WAYS);
    else ways_eff = WCNT_W'(ways_r);
  end

  // Lookup over the row read from memory.
  entry_t           ent [MAX_WAYS];
  entry_t           new_ent [MAX_WAYS];
  logic             hit;
  logic [WAY_W-1:0] hit_way;
  logic             has_free;
  logic [WAY_W-1:0] free_way;
  logic [WAY_W-1:0] old_way;
  logic [AGE_W-1:0] old_age;
  logic [WAY_W-1:0] tgt_way;
  logic [AGE_W-1:0] hit_age;
  logic [1:0]       outcome;
  always_comb begin
    hit = 1'b0; hit_way = '0; has_free = 1'b0; free_way = '0;
    old_way = '0; old_age = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      ent[w] = rd_row_r[w*ENT_W +: ENT_W];
    end
    old_age = ent[0].age;
    for (int w = MAX_WAYS-1; w >= 0; w--) begin
      if (WCNT_W'(w) < ways_eff) begin
        if (ent[w].valid && ent[w].tag == tag_r) begin
          hit = 1'b1; hit_way = WAY_W'(w);
        end
        if (!ent[w].valid) begin
          has_free = 1'b1; free_way = WAY_W'(w);
        end
      end
    end
    for (int w = 1; w < MAX_WAYS; w++) begin
      if (WCNT_W'(w) < ways_eff && ent[w].age > old_age) begin
        old_age = ent[w].age; old_way = WAY_W'(w);
      end
    end
    hit_age = ent[hit_way].age;
    tgt_way = hit ? hit_way : (has_free ? free_way : old_way);
    outcome = hit ? OUT_HIT : (has_free ? OUT_FILL : OUT_EVICT);
    for (int w = 0; w < MAX_WAYS; w++) begin
      new_ent[w] = ent[w];
      if (WCNT_W'(w) < ways_eff) begin
        if (WAY_W'(w) == tgt_way) begin
          new_ent[w].valid = 1'b1;
          new_ent[w].tag   = tag_r;
          new_ent[w].age   = '0;
        end else if (ent[w].valid && (!hit || ent[w].age < hit_age)) begin
          new_ent[w].age = age_inc(ent[w].age);
        end
      end
    end
  end

  logic [ROW_W-1:0] upd_row;
  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) upd_row[w*ENT_W +: ENT_W] = new_ent[w];
  end

  logic in_fire, out_fire, out_free;
  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;
  assign out_free = !ovalid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r; clr_cnt_nxt = clr_cnt_r;
    set_nxt = set_r; tag_nxt = tag_r; second_nxt = second_r; modify_nxt = modify_r;
    hits_nxt = hits_r; miss_nxt = miss_r; evict_nxt = evict_r;
    ovalid_nxt = ovalid_r && !out_fire; oout_nxt = oout_r; olast_nxt = olast_r;
    mem_we = 1'b0; mem_waddr = set_r; mem_wrow = upd_row; mem_re = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1; mem_waddr = clr_cnt_r[SET_W-1:0]; mem_wrow = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == (SET_W+1)'(MAX_SETS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire && req_type != REQ_IFETCH) begin
          // wrap the index modulo MAX_SETS (a power of two)
          set_nxt    = idx_full[SET_W-1:0];
          tag_nxt    = tag_full[TAG_W-1:0];
          modify_nxt = (req_type == REQ_MODIFY);
          second_nxt = 1'b0;
          state_nxt  = ST_READ;
        end
      end
      ST_READ: begin
        mem_re = 1'b1; state_nxt = ST_COMP;
      end
      ST_COMP: begin
        // hold until the output register frees up
        if (out_free) begin
          mem_we = 1'b1;
          if (hit) hits_nxt = sat_inc(hits_r);
          else miss_nxt = sat_inc(miss_r);
          if (!hit && !has_free) evict_nxt = sat_inc(evict_r);
          ovalid_nxt = 1'b1; oout_nxt = outcome;
          olast_nxt  = !modify_r || second_r;
          if (modify_r && !second_r) begin
            second_nxt = 1'b1; state_nxt = ST_READ;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wrow;
    if (mem_re) rd_row_r <= mem[set_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR; clr_cnt_r <= '0;
      set_bits_r <= 4'd1; ways_r <= 4'd1; blk_bits_r <= 6'd1;
      hits_r <= '0; miss_r <= '0; evict_r <= '0;
      ovalid_r <= 1'b0; second_r <= 1'b0; modify_r <= 1'b0;
    end else begin
      state_r <= state_nxt; clr_cnt_r <= clr_cnt_nxt;
      hits_r <= hits_nxt; miss_r <= miss_nxt; evict_r <= evict_nxt;
      ovalid_r <= ovalid_nxt; second_r <= second_nxt; modify_r <= modify_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_SET_BITS: set_bits_r <= cfg_wdata[3:0];
          CFG_WAYS:     ways_r     <= cfg_wdata[3:0];
          CFG_BLK_BITS: blk_bits_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    set_r <= set_nxt; tag_r <= tag_nxt;
    oout_r <= oout_nxt; olast_r <= olast_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = {6'd0, evict_r, miss_r, hits_r, oout_r};

  `SALC_ASSERT_IMPL(a_no_accept_clear, clk, rst_n, state_r == ST_CLEAR, !in_tready)
  `SALC_ASSERT_NEXT(a_read_then_comp, clk, rst_n, state_r == ST_READ, state_r == ST_COMP)
  `SALC_ASSERT_IMPL(a_evict_le_miss, clk, rst_n, 1'b1, evict_r <= miss_r)
  `SALC_ASSERT_IMPL(a_no_emit_code, clk, rst_n, ovalid_r, oout_r != 2'd3)
endmodule

// ----- tb/tb_set_assoc_lru_cache_model.sv -----
// Testbench for the set-associative LRU cache model: directed table plus random traffic.
module tb_set_assoc_lru_cache_model;
  import salc_pkg::*;

  localparam int NSETS = MAX_SETS_DEF;
  localparam int NWAYS = MAX_WAYS_DEF;

  typedef struct packed {
    logic [1:0]  outcome;
    logic [31:0] hits;
    logic [31:0] misses;
    logic [31:0] evicts;
    logic        last;
  } lookup_res_t;

  typedef struct {
    logic [1:0]  kind;
    logic [63:0] addr;
    bit          typed;   // expected outcome typed in below
    logic [1:0]  want;    // outcome of the first lookup
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [5:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic out_tlast;

  set_assoc_lru_cache_model u_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: shadow of the cache and its registers.
  logic [3:0]  set_bits_q;
  logic [3:0]  ways_q;
  logic [5:0]  blk_bits_q;
  bit          row_valid [NSETS][NWAYS];
  logic [63:0] row_tag   [NSETS][NWAYS];
  logic [2:0]  row_age   [NSETS][NWAYS];
  logic [31:0] hits_q, misses_q, evicts_q;

  lookup_res_t pending_results[$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  function automatic logic [31:0] bump(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  // Do one lookup on the shadow cache and return the predicted result.
  function automatic lookup_res_t cache_lookup(input logic [63:0] addr, input bit last);
    lookup_res_t r;
    int unsigned sh, nw, set, hitw, vic;
    logic [63:0] idx, tag;
    logic [2:0] ha, oldest;
    sh = set_bits_q + blk_bits_q;
    idx = (addr >> blk_bits_q) & ((64'd1 << set_bits_q) - 64'd1);
    tag = (sh >= 64) ? 64'd0 : (addr >> sh);
    nw = (ways_q < 1) ? 1 : (ways_q > NWAYS) ? NWAYS : ways_q;
    set = idx % NSETS;
    hitw = nw;
    for (int i = nw - 1; i >= 0; i--)
      if (row_valid[set][i] && row_tag[set][i] == tag) hitw = i;
    if (hitw < nw) begin
      ha = row_age[set][hitw];
      for (int j = 0; j < nw; j++)
        if (j != hitw && row_valid[set][j] && row_age[set][j] < ha)
          row_age[set][j] = row_age[set][j] + 3'd1;
      row_age[set][hitw] = 3'd0;
      hits_q = bump(hits_q);
      r.outcome = OUT_HIT;
    end else begin
      misses_q = bump(misses_q);
      vic = nw;
      for (int i = nw - 1; i >= 0; i--)
        if (!row_valid[set][i]) vic = i;
      if (vic < nw) begin
        r.outcome = OUT_FILL;
      end else begin
        vic = 0;
        oldest = row_age[set][0];
        for (int i = 1; i < nw; i++)
          if (row_age[set][i] > oldest) begin
            oldest = row_age[set][i];
            vic = i;
          end
        evicts_q = bump(evicts_q);
        r.outcome = OUT_EVICT;
      end
      row_valid[set][vic] = 1'b1;
      row_tag[set][vic] = tag;
      row_age[set][vic] = 3'd0;
      for (int j = 0; j < nw; j++)
        if (j != vic && row_valid[set][j] && row_age[set][j] != 3'd7)
          row_age[set][j] = row_age[set][j] + 3'd1;
    end
    r.hits = hits_q;
    r.misses = misses_q;
    r.evicts = evicts_q;
    r.last = last;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %0h, want %0h", what, got, want);
    mismatches++;
  endtask

  // Drive the receiver and compare each accepted result item.
  always @(posedge clk) begin
    lookup_res_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected item", out_tdata[63:0], 64'd0);
      end else begin
        w = pending_results.pop_front();
        if (out_tdata[1:0] !== w.outcome) report_mismatch("outcome", out_tdata[1:0], w.outcome);
        if (out_tdata[33:2] !== w.hits) report_mismatch("hit_total", out_tdata[33:2], w.hits);
        if (out_tdata[65:34] !== w.misses)
          report_mismatch("miss_total", out_tdata[65:34], w.misses);
        if (out_tdata[97:66] !== w.evicts)
          report_mismatch("evict_total", out_tdata[97:66], w.evicts);
        if (out_tdata[103:98] !== 6'd0) report_mismatch("pad", out_tdata[103:98], 0);
        if (out_tlast !== w.last) report_mismatch("tlast", out_tlast, w.last);
      end
    end
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Send one item and predict its results on acceptance; tvalid stays high
  // until the next item or an idle cycle drops it.
  task automatic send_item(input logic [1:0] kind, input logic [63:0] addr,
                           input bit typed, input logic [1:0] want);
    lookup_res_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, addr, kind};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (kind == REQ_LOAD || kind == REQ_STORE) begin
      r = cache_lookup(addr, 1'b1);
      if (typed && r.outcome != want) report_mismatch("table row", r.outcome, want);
      pending_results.push_back(r);
    end else if (kind == REQ_MODIFY) begin
      r = cache_lookup(addr, 1'b0);
      if (typed && r.outcome != want) report_mismatch("table row", r.outcome, want);
      pending_results.push_back(r);
      pending_results.push_back(cache_lookup(addr, 1'b1));
    end
  endtask

  // Wait until every result has drained, then let the pipeline settle.
  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write a register while idle; index 3 lies past the list and is ignored.
  task automatic write_cfg(input logic [1:0] index, input logic [5:0] value);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (index)
      CFG_SET_BITS: set_bits_q = value[3:0];
      CFG_WAYS:     ways_q = value[3:0];
      CFG_BLK_BITS: blk_bits_q = value;
      default: ;
    endcase
  endtask

  task automatic setup(input int s, input int w, input int b);
    drain();
    write_cfg(CFG_SET_BITS, s[5:0]);
    write_cfg(CFG_WAYS, w[5:0]);
    write_cfg(CFG_BLK_BITS, b[5:0]);
  endtask

  function automatic logic [63:0] rand64;
    return {$urandom, $urandom};
  endfunction

  // Directed table; outcomes read straight off the model after reset
  // (one way, 2 sets, 2-byte blocks).
  stim_row_t dir_rows[] = '{
    '{REQ_LOAD,   64'h0,                    1, OUT_FILL},
    '{REQ_STORE,  64'h1,                    1, OUT_HIT},
    '{REQ_LOAD,   64'h4,                    1, OUT_EVICT},
    '{REQ_MODIFY, 64'h5,                    1, OUT_HIT},
    '{REQ_IFETCH, 64'h0,                    0, OUT_HIT},
    '{REQ_LOAD,   64'h2,                    1, OUT_FILL},
    '{REQ_LOAD,   64'hFFFF_FFFF_FFFF_FFFF,  1, OUT_EVICT},
    '{REQ_STORE,  64'hFFFF_FFFF_FFFF_FFFE,  1, OUT_HIT},
    '{REQ_MODIFY, 64'h8000_0000_0000_0000,  1, OUT_EVICT},
    '{REQ_IFETCH, 64'hFFFF_FFFF_FFFF_FFFF,  0, OUT_HIT},
    '{REQ_LOAD,   64'h8000_0000_0000_0001,  1, OUT_HIT}
  };

  // Random traffic: mostly addresses from a small pool so sets fill, hit and evict.
  task automatic random_phase(input int n, input int s, input int w, input int b);
    logic [63:0] pool[16];
    logic [63:0] a;
    setup(s, w, b);
    foreach (pool[i]) pool[i] = rand64();
    for (int k = 0; k < n; k++) begin
      a = ($urandom_range(9) < 8) ? pool[$urandom_range(15)] ^ 64'($urandom_range(3))
                                  : rand64();
      if ($urandom_range(9) == 0) a = pool[$urandom_range(15)] + (64'd1 << (s + b));
      send_item(2'($urandom_range(3)), a, 0, OUT_HIT);
    end
  endtask

  initial begin
    set_bits_q = 4'd1; ways_q = 4'd1; blk_bits_q = 6'd1;
    hits_q = '0; misses_q = '0; evicts_q = '0;
    foreach (row_valid[i, j]) begin
      row_valid[i][j] = 1'b0;
      row_tag[i][j] = '0;
      row_age[i][j] = '0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_item(dir_rows[i].kind, dir_rows[i].addr, dir_rows[i].typed, dir_rows[i].want);

    // Edge settings: ways 0 and above the maximum, index past the list,
    // shift of 64 or more, set index beyond the set count.
    drain();
    write_cfg(2'd3, 6'h3F);
    setup(15, 0, 63);
    for (int k = 0; k < 6; k++) send_item(REQ_MODIFY, rand64(), 0, OUT_HIT);
    setup(12, 15, 1);
    for (int k = 0; k < 12; k++) send_item(REQ_LOAD, {$urandom, 32'd0} | 64'(k), 0, OUT_HIT);

    send_idle_pct = 8; recv_idle_pct = 54;
    random_phase(300, 1, 8, 32);
    random_phase(250, 2, 4, 6);
    // Hold off until every result is home.
    drain();
    send_idle_pct = 54; recv_idle_pct = 8;
    random_phase(300, 10, 8, 1);
    random_phase(250, 0, 2, 4);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_phase(300, 3, 3, 0);
    random_phase(300, 1, 1, 5);

    drain();
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #20000000;
    $display("Mismatches found");
    $finish;
  end
endmodule

// ----- set_assoc_lru_cache_model.f -----
+incdir+src
src/salc_pkg.sv
src/set_assoc_lru_cache_model.sv
tb/tb_set_assoc_lru_cache_model.sv
